// ===== rtl/ptae_pkg.sv =====
// Package for the polynomial term accumulator and evaluator.
// Holds the item types, the controller state type and the default slot count; no dependencies.
`default_nettype none

package ptae_pkg;

    // Default number of coefficient slots (degrees 0 .. DEGREE_SLOTS_DEF-1)
    localparam int DEGREE_SLOTS_DEF = 64;

    // One incoming polynomial term
    typedef struct packed {
        logic               mode;
        logic signed [31:0] coefficient;
        logic        [7:0]  degree;
        logic               last;
    } t_term;

    // One evaluation result
    typedef struct packed {
        logic signed [63:0] value;
        logic        [6:0]  term_count;
        logic        [5:0]  top_degree;
        logic               degree_error;
    } t_result;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READ,
        ST_MUL_HI,
        ST_ADD,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/poly_term_accumulate_evaluate.sv =====
// Top level of the polynomial term accumulator and evaluator.
// Uses ptae_pkg for the item types, the state type and the default slot count.
//
// Terms enter one at a time; each is a read-modify-write of one slot in a
// coefficient memory with a registered read, so a term is read, then written
// back, and the input stalls during the write-back. A term with the
// last mark then starts a Horner walk from the top slot down: one shared
// 33x32 multiplier forms the two halves of the 64-bit product, so each slot
// is read with the low product formed, then gets the high product and a slot
// clear, then the add, and the result is loaded once the walk has ended and
// the output register is free. The walk writes zero behind itself, so the
// store is empty for the next polynomial. After reset a clearing pass zeroes
// the memory while the input stalls; eval_point writes are taken at any time.
`default_nettype none

module poly_term_accumulate_evaluate #(
    parameter int DEGREE_SLOTS = ptae_pkg::DEGREE_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic signed [31:0] i_cfg_data,
    input  wire logic               i_term_valid,
    input  wire ptae_pkg::t_term    i_term,
    output logic                    o_term_stall,
    output logic                    o_result_valid,
    output ptae_pkg::t_result       o_result,
    input  wire logic               i_result_stall
);

    localparam int AW = $clog2(DEGREE_SLOTS);
    localparam int DW = AW + 8;
    localparam int TW = AW + 6;
    localparam logic [AW-1:0] TOP_IDX = AW'(DEGREE_SLOTS - 1);

    // Coefficient memory
    logic [31:0] r_mem [DEGREE_SLOTS];
    logic [31:0] r_rd_data;
    logic        mem_re;
    logic [AW-1:0] mem_ra;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0] mem_wd;

    // Control and datapath registers
    ptae_pkg::t_state r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_eval_point;
    logic [31:0]        r_coef, n_coef;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_in_range, n_in_range;
    logic               r_last, n_last;
    logic               r_error, n_error;
    logic [63:0]        r_acc, n_acc;
    logic [63:0]        r_prod_lo, n_prod_lo;
    logic [31:0]        r_prod_hi, n_prod_hi;
    logic [6:0]         r_count, n_count;
    logic [5:0]         r_top, n_top;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;
    ptae_pkg::t_result  r_out, n_out;

    logic               term_accept;
    logic [DW-1:0]      deg_w;
    logic [TW-1:0]      idx_w;
    logic signed [32:0] mul_a;
    logic signed [64:0] mul_p;
    logic               out_free;

    assign term_accept = i_term_valid && !o_term_stall;
    assign deg_w       = DW'(i_term.degree);
    assign idx_w       = TW'(r_idx);
    assign out_free    = !r_out_valid || !i_result_stall;

    // Share one multiplier between the low and high halves of the accumulator
    always_comb begin
        if (r_state == ptae_pkg::ST_READ) begin
            mul_a = $signed({1'b0, r_acc[31:0]});
        end else begin
            mul_a = $signed({r_acc[63], r_acc[63:32]});
        end
        mul_p = 65'(mul_a) * 65'(r_eval_point);
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // Next state, memory control and datapath updates
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_coef      = r_coef;
        n_addr      = r_addr;
        n_in_range  = r_in_range;
        n_last      = r_last;
        n_error     = r_error;
        n_acc       = r_acc;
        n_prod_lo   = r_prod_lo;
        n_prod_hi   = r_prod_hi;
        n_count     = r_count;
        n_top       = r_top;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_result_stall;
        o_term_stall = 1'b1;
        mem_re      = 1'b0;
        mem_ra      = r_idx;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = '0;

        unique case (r_state)
            // Zero the memory one slot at a time after reset, from the top slot down
            ptae_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == '0) begin
                    n_state = ptae_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            // Take a term and read its slot
            ptae_pkg::ST_IDLE: begin
                o_term_stall = 1'b0;
                mem_ra = deg_w[AW-1:0];
                if (term_accept) begin
                    mem_re     = 1'b1;
                    n_coef     = i_term.mode ? (32'd0 - i_term.coefficient)
                                             : i_term.coefficient;
                    n_addr     = deg_w[AW-1:0];
                    n_in_range = deg_w < DW'(DEGREE_SLOTS);
                    n_last     = i_term.last;
                    n_state    = ptae_pkg::ST_UPDATE;
                end
            end
            // Write back the combined coefficient, or flag a dropped term; a last term starts the walk
            ptae_pkg::ST_UPDATE: begin
                mem_wa = r_addr;
                mem_wd = r_rd_data + r_coef;
                if (r_in_range) begin
                    mem_we = 1'b1;
                end else begin
                    n_error = 1'b1;
                end
                if (r_last) begin
                    n_idx   = TOP_IDX;
                    n_acc   = '0;
                    n_count = '0;
                    n_top   = '0;
                    n_found = 1'b0;
                    n_state = ptae_pkg::ST_READ;
                end else begin
                    n_state = ptae_pkg::ST_IDLE;
                end
            end
            // Read the slot, form the low product
            ptae_pkg::ST_READ: begin
                mem_re    = 1'b1;
                n_prod_lo = mul_p[63:0];
                n_state   = ptae_pkg::ST_MUL_HI;
            end
            // Form the high product, clear the slot behind the walk
            ptae_pkg::ST_MUL_HI: begin
                n_prod_hi = mul_p[31:0];
                mem_we    = 1'b1;
                n_state   = ptae_pkg::ST_ADD;
            end
            // Horner step, count and track the top nonzero slot
            ptae_pkg::ST_ADD: begin
                n_acc = r_prod_lo + {r_prod_hi, 32'd0} + {{32{r_rd_data[31]}}, r_rd_data};
                if (r_rd_data != '0) begin
                    n_count = r_count + 7'd1;
                    if (!r_found) begin
                        n_found = 1'b1;
                        n_top   = idx_w[5:0];
                    end
                end
                if (r_idx == '0) begin
                    n_state = ptae_pkg::ST_FINISH;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = ptae_pkg::ST_READ;
                end
            end
            // Hand the result to the output register once it is free
            ptae_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out.value        = r_acc;
                    n_out.term_count   = r_count;
                    n_out.top_degree   = r_top;
                    n_out.degree_error = r_error;
                    n_out_valid        = 1'b1;
                    n_error            = 1'b0;
                    n_state            = ptae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptae_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptae_pkg::ST_CLEAR;
            r_idx        <= TOP_IDX;
            r_error      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_eval_point <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_error     <= n_error;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_eval_point <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_coef     <= n_coef;
        r_addr     <= n_addr;
        r_in_range <= n_in_range;
        r_last     <= n_last;
        r_acc      <= n_acc;
        r_prod_lo  <= n_prod_lo;
        r_prod_hi  <= n_prod_hi;
        r_count    <= n_count;
        r_top      <= n_top;
        r_found    <= n_found;
        r_out      <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef ASSERT_OFF
    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptae_pkg::ST_IDLE && i_term_valid) |=> r_state == ptae_pkg::ST_UPDATE)
        else $error("accepted item did not move to write-back");

    a_plain_term_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptae_pkg::ST_UPDATE && !r_last) |=> r_state == ptae_pkg::ST_IDLE)
        else $error("term without last mark did not return to idle");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ptae_pkg::ST_UPDATE || r_state == ptae_pkg::ST_MUL_HI ||
                    r_state == ptae_pkg::ST_CLEAR))
        else $error("memory written outside update, walk or clear");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptae_pkg::ST_FINISH && out_free) |=> r_out_valid)
        else $error("finished walk did not load the result");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for poly_term_accumulate_evaluate: directed and random polynomials,
// checked against a behavioral predictor of the accumulate and evaluate steps.
// Depends on ptae_pkg (item types, slot count) and the block's top module.
`default_nettype none

module tb_top;

    localparam int SLOTS        = ptae_pkg::DEGREE_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 800;
    // Horner walk length plus margin; used before register writes and at the end
    localparam int SETTLE       = 3 * SLOTS + 8;
    // Long enough for a waiting result and a second finished walk to back up
    localparam int HOLD_CYCLES  = 1000;
    localparam int IDLE_LIMIT   = 4000;
    localparam int IDLE_PCT     = 38;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_SUB = 1'b1;

    typedef enum logic {ROW_TERM, ROW_POINT} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        ptae_pkg::t_term   term;
        logic [31:0]       point;
        bit                typed;
        ptae_pkg::t_result res;
    } t_dir_row;

    logic              i_clk        = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [31:0]       cfg_data     = '0;
    logic              term_valid   = 1'b0;
    ptae_pkg::t_term   term_bus     = '0;
    logic              result_stall = 1'b0;
    logic              o_term_stall;
    logic              o_result_valid;
    ptae_pkg::t_result o_result;

    // Predictor state
    logic [31:0]       slot_coeff [SLOTS];
    bit                degree_fault = 1'b0;
    logic [31:0]       eval_x       = '0;
    ptae_pkg::t_result pending_results [$];

    // Directed stimulus table
    t_dir_row dir_rows [$];

    int  fault_count     = 0;
    bit  sender_may_idle = 1'b1;
    bit  hold_req        = 1'b0;
    bit  hold_done       = 1'b0;
    int  hold_left       = 0;
    int  idle_cycles     = 0;

    poly_term_accumulate_evaluate #(
        .DEGREE_SLOTS(SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_term_valid   (term_valid),
        .i_term         (term_bus),
        .o_term_stall   (o_term_stall),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_result_stall (result_stall)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Add one term into the slot store; on a last term evaluate, then clear
    function automatic bit accumulate_term(input ptae_pkg::t_term t,
                                           output ptae_pkg::t_result r);
        logic [31:0] c;
        logic [63:0] acc;
        logic [63:0] x;
        int          n;
        int          hi;
        c = t.coefficient;
        if (t.mode == MODE_SUB) c = -c;
        if (t.degree < SLOTS) slot_coeff[t.degree] = slot_coeff[t.degree] + c;
        else degree_fault = 1'b1;
        r = '0;
        if (!t.last) return 1'b0;
        x   = {{32{eval_x[31]}}, eval_x};
        acc = '0;
        n   = 0;
        hi  = 0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            acc = acc * x + {{32{slot_coeff[i][31]}}, slot_coeff[i]};
            if (slot_coeff[i] != 0) begin
                n++;
                if (i > hi) hi = i;
            end
        end
        r.value        = acc;
        r.term_count   = 7'(n);
        r.top_degree   = 6'(hi);
        r.degree_error = degree_fault;
        for (int i = 0; i < SLOTS; i++) slot_coeff[i] = '0;
        degree_fault = 1'b0;
        return 1'b1;
    endfunction

    function automatic ptae_pkg::t_term make_term(logic mode, logic [31:0] coef,
                                                  logic [7:0] deg, logic last);
        ptae_pkg::t_term t;
        t.mode        = mode;
        t.coefficient = coef;
        t.degree      = deg;
        t.last        = last;
        return t;
    endfunction

    function automatic t_dir_row term_row(logic mode, logic [31:0] coef, logic [7:0] deg,
                                          logic last);
        t_dir_row row;
        row.kind  = ROW_TERM;
        row.term  = make_term(mode, coef, deg, last);
        row.point = '0;
        row.typed = 1'b0;
        row.res   = '0;
        return row;
    endfunction

    function automatic t_dir_row point_row(logic [31:0] v);
        t_dir_row row;
        row       = term_row(MODE_ADD, '0, '0, 1'b0);
        row.kind  = ROW_POINT;
        row.point = v;
        return row;
    endfunction

    function automatic t_dir_row checked(t_dir_row row, logic [63:0] value, int cnt, int top,
                                         logic err);
        row.typed            = 1'b1;
        row.res.value        = value;
        row.res.term_count   = 7'(cnt);
        row.res.top_degree   = 6'(top);
        row.res.degree_error = err;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_point();
        case ($urandom_range(8))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd2;
            4:       return 32'hFFFF_FFFE;
            5:       return 32'h7FFF_FFFF;
            6:       return 32'h8000_0000;
            7:       return 32'($urandom_range(20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    // Offer one item, hold it until accepted, then predict its result
    task automatic send_term(input ptae_pkg::t_term t, input bit typed,
                             input ptae_pkg::t_result typed_res);
        ptae_pkg::t_result r;
        while (sender_may_idle && $urandom_range(99) < IDLE_PCT) begin
            term_valid <= 1'b0;
            @(negedge i_clk);
        end
        term_valid <= 1'b1;
        term_bus   <= t;
        do @(posedge i_clk); while (o_term_stall);
        if (accumulate_term(t, r)) begin
            pending_results.insert(pending_results.size(), typed ? typed_res : r);
        end
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every expected result, then let the walk finish
    task automatic wait_drained();
        term_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_eval_point(input logic [31:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        eval_x    = v;
    endtask

    // Result receiver: random stalls, one long hold-off, no stalls while the sender
    // runs without gaps
    always @(negedge i_clk) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else if (hold_left != 0) begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            result_stall <= 1'b1;
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else if (!sender_may_idle) begin
            result_stall <= 1'b0;
        end else begin
            result_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        ptae_pkg::t_result want;
        if (rst_n && o_result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                log_fault($sformatf("unexpected result: value %0d count %0d top %0d err %0b",
                                    o_result.value, o_result.term_count,
                                    o_result.top_degree, o_result.degree_error));
            end else begin
                want = pending_results.pop_front();
                if (o_result.value !== want.value ||
                    o_result.term_count !== want.term_count ||
                    o_result.top_degree !== want.top_degree ||
                    o_result.degree_error !== want.degree_error) begin
                    log_fault($sformatf({"result mismatch: expected value %0d count %0d ",
                                         "top %0d err %0b, got value %0d count %0d top %0d ",
                                         "err %0b"},
                                        want.value, want.term_count, want.top_degree,
                                        want.degree_error, o_result.value,
                                        o_result.term_count, o_result.top_degree,
                                        o_result.degree_error));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((term_valid && !o_term_stall) || (o_result_valid && !result_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        ptae_pkg::t_term poly_terms [$];
        ptae_pkg::t_term t;
        int              style;
        int              len;
        int              full_polys;
        int              poly_index;
        int              offset;
        int              random_sent;

        for (int i = 0; i < SLOTS; i++) slot_coeff[i] = '0;
        full_polys = 0;
        poly_index = 0;

        // Evaluation point still at its reset value of zero
        add_row(checked(term_row(MODE_ADD, 32'd0, 8'd0, 1'b1), 64'd0, 0, 0, 1'b0));
        add_row(checked(term_row(MODE_ADD, 32'd5, 8'd255, 1'b1), 64'd0, 0, 0, 1'b1));
        add_row(checked(term_row(MODE_ADD, 32'h7FFF_FFFF, 8'd0, 1'b1),
                        64'd2147483647, 1, 0, 1'b0));
        // Negating the most negative coefficient wraps back onto itself
        add_row(term_row(MODE_SUB, 32'h8000_0000, 8'd63, 1'b0));
        add_row(checked(term_row(MODE_ADD, 32'd1, 8'd0, 1'b1), 64'd1, 2, 63, 1'b0));
        // Terms that cancel, closed by an out-of-range last term
        add_row(term_row(MODE_ADD, 32'd7, 8'd5, 1'b0));
        add_row(term_row(MODE_SUB, 32'd7, 8'd5, 1'b0));
        add_row(checked(term_row(MODE_ADD, 32'd1, 8'd64, 1'b1), 64'd0, 0, 0, 1'b1));
        // Slot sum overflows at 32 bits
        add_row(term_row(MODE_ADD, 32'h7FFF_FFFF, 8'd1, 1'b0));
        add_row(checked(term_row(MODE_ADD, 32'd1, 8'd1, 1'b1), 64'd0, 1, 1, 1'b0));
        add_row(point_row(32'hFFFF_FFFF));
        add_row(term_row(MODE_ADD, 32'hFFFF_FFFF, 8'd63, 1'b0));
        add_row(term_row(MODE_SUB, 32'h8000_0000, 8'd62, 1'b0));
        add_row(term_row(MODE_ADD, 32'd3, 8'd0, 1'b1));
        add_row(point_row(32'h7FFF_FFFF));
        add_row(term_row(MODE_ADD, 32'h7FFF_FFFF, 8'd63, 1'b0));
        add_row(term_row(MODE_SUB, 32'hFFFF_FFFF, 8'd2, 1'b0));
        add_row(term_row(MODE_ADD, 32'h8000_0000, 8'd1, 1'b1));
        add_row(point_row(32'h8000_0000));
        add_row(term_row(MODE_ADD, 32'h8000_0000, 8'd63, 1'b0));
        add_row(term_row(MODE_ADD, 32'd1, 8'd10, 1'b0));
        add_row(term_row(MODE_ADD, 32'd0, 8'd200, 1'b1));
        add_row(point_row(32'd1));
        add_row(term_row(MODE_ADD, 32'd5, 8'd3, 1'b0));
        add_row(checked(term_row(MODE_SUB, 32'd2, 8'd3, 1'b1), 64'd3, 1, 3, 1'b0));

        // Hold reset, then release at a falling edge
        repeat (12) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_POINT) set_eval_point(dir_rows[k].point);
            else send_term(dir_rows[k].term, dir_rows[k].typed, dir_rows[k].res);
        end

        // Random polynomials
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (poly_index % 8 == 7) set_eval_point(rand_point());
            if (poly_index == 3) hold_req = 1'b1;
            poly_terms.delete();
            style = $urandom_range(99);
            if (style < 4 && full_polys < 3) begin
                // Fill every slot once
                full_polys++;
                offset = $urandom_range(SLOTS - 1);
                for (int d = 0; d < SLOTS; d++) begin
                    t = make_term(1'($urandom_range(1)), rand_coef() | 32'd1,
                                  8'((d + offset) % SLOTS), 1'b0);
                    poly_terms.insert(poly_terms.size(), t);
                end
            end else if (style < 20) begin
                // Few slots, small values: like terms collide and often cancel
                len = $urandom_range(8, 2);
                for (int j = 0; j < len; j++) begin
                    t = make_term(1'($urandom_range(1)), 32'($urandom_range(2, 1)),
                                  8'($urandom_range(3)), 1'b0);
                    poly_terms.insert(poly_terms.size(), t);
                    if ($urandom_range(1)) begin
                        t.mode = ~t.mode;
                        poly_terms.insert(poly_terms.size(), t);
                    end
                end
            end else if (style < 28) begin
                // Mostly out-of-range degrees
                len = $urandom_range(4, 1);
                for (int j = 0; j < len; j++) begin
                    t = make_term(1'($urandom_range(1)), rand_coef(),
                                  8'($urandom_range(255, SLOTS / 2)), 1'b0);
                    poly_terms.insert(poly_terms.size(), t);
                end
            end else begin
                len = $urandom_range(10, 1);
                for (int j = 0; j < len; j++) begin
                    t = make_term(1'($urandom_range(1)), rand_coef(),
                                  ($urandom_range(19) == 0) ?
                                      8'($urandom_range(255, SLOTS)) :
                                      8'($urandom_range(SLOTS - 1)),
                                  1'b0);
                    poly_terms.insert(poly_terms.size(), t);
                end
            end
            poly_terms[poly_terms.size() - 1].last = 1'b1;
            foreach (poly_terms[j]) begin
                sender_may_idle = !(random_sent >= 300 && random_sent < 450);
                send_term(poly_terms[j], 1'b0, '0);
                random_sent++;
            end
            poly_index++;
        end

        // Drain and report
        wait_drained();
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ptae_pkg.sv
rtl/poly_term_accumulate_evaluate.sv
test/tb_top.sv
